// ===== rtl/lmbp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbp_pkg
// Shared types and constants for the LED matrix bit-plane packer.
// ----------------------------------------------------------------------------
package lmbp_pkg;

    localparam int COLOR_W       = 24;
    localparam int PAL_IDX_W     = 4;
    localparam int PAL_DEPTH     = 16;
    localparam int ROW_ADDR_W    = 5;
    localparam int BSEL_W        = 3;
    localparam int THR_W         = 6;
    localparam int WORD_W        = 32;
    localparam int ACC_W         = 24;
    localparam int ROW_WIDTH_DEF = 64;

    typedef logic [COLOR_W-1:0]    color_t;
    typedef logic [PAL_IDX_W-1:0]  pal_idx_t;
    typedef logic [ROW_ADDR_W-1:0] row_addr_t;
    typedef logic [BSEL_W-1:0]     bsel_t;
    typedef logic [THR_W-1:0]      thr_t;
    typedef logic [WORD_W-1:0]     word_t;

    typedef enum logic [0:0] {
        OP_PIXEL   = 1'b0,
        OP_PALETTE = 1'b1
    } opcode_t;

    localparam pal_idx_t PAL_NONE = '0;

    // Palette write request
    typedef struct packed {
        logic     en;
        pal_idx_t idx;
        color_t   color;
    } pal_wr_t;

    // Pixel request handed to the plane packer
    typedef struct packed {
        logic     load;
        color_t   upper_color;
        color_t   lower_color;
        pal_idx_t upper_overlay;
        pal_idx_t lower_overlay;
        bsel_t    bit_select;
        row_addr_t row_index;
    } pix_req_t;

endpackage

// ===== rtl/lmbp_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbp_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lmbp_ram #(
    parameter int WIDTH = lmbp_pkg::COLOR_W,
    parameter int DEPTH = lmbp_pkg::PAL_DEPTH
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/lmbp_palette.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbp_palette
// Overlay palette: two RAM copies for two read ports, per-entry valid bits.
// ----------------------------------------------------------------------------
module lmbp_palette (
    input  logic               clk,
    input  logic               rst_n,
    input  lmbp_pkg::pal_wr_t  wr,
    input  logic               rd_en,
    input  lmbp_pkg::pal_idx_t rd_idx_upper,
    input  lmbp_pkg::pal_idx_t rd_idx_lower,
    output lmbp_pkg::color_t   pal_upper,
    output lmbp_pkg::color_t   pal_lower
);

    logic [lmbp_pkg::PAL_DEPTH-1:0] valid_reg;
    logic [lmbp_pkg::PAL_DEPTH-1:0] valid_next;
    logic                           hit_upper_reg;
    logic                           hit_lower_reg;
    logic                           we;
    lmbp_pkg::color_t               rdata_upper;
    lmbp_pkg::color_t               rdata_lower;

    // entry zero means no overlay; drop writes to it
    assign we = wr.en && (wr.idx != lmbp_pkg::PAL_NONE);

    always_comb
    begin
        valid_next = valid_reg;
        if (we)
        begin
            valid_next[wr.idx] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg     <= '0;
            hit_upper_reg <= 1'b0;
            hit_lower_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (rd_en)
            begin
                hit_upper_reg <= valid_reg[rd_idx_upper];
                hit_lower_reg <= valid_reg[rd_idx_lower];
            end
        end
    end

    lmbp_ram #(
        .WIDTH (lmbp_pkg::COLOR_W),
        .DEPTH (lmbp_pkg::PAL_DEPTH)
    ) u_ram_upper (
        .clk   (clk),
        .we    (we),
        .waddr (wr.idx),
        .wdata (wr.color),
        .re    (rd_en),
        .raddr (rd_idx_upper),
        .rdata (rdata_upper)
    );

    lmbp_ram #(
        .WIDTH (lmbp_pkg::COLOR_W),
        .DEPTH (lmbp_pkg::PAL_DEPTH)
    ) u_ram_lower (
        .clk   (clk),
        .we    (we),
        .waddr (wr.idx),
        .wdata (wr.color),
        .re    (rd_en),
        .raddr (rd_idx_lower),
        .rdata (rdata_lower)
    );

    // entries never written read as zero
    assign pal_upper = hit_upper_reg ? rdata_upper : '0;
    assign pal_lower = hit_lower_reg ? rdata_lower : '0;

    assert property (@(posedge clk) disable iff (!rst_n) !valid_reg[0])
        else $error("palette entry zero marked valid");

endmodule

// ===== rtl/lmbp_plane_pack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmbp_plane_pack
// Pixel stage: resolve overlay, extract plane bits, pack words, output reg.
// ----------------------------------------------------------------------------
module lmbp_plane_pack #(
    parameter int ROW_WIDTH = lmbp_pkg::ROW_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lmbp_pkg::thr_t        threshold,
    input  lmbp_pkg::pix_req_t    req,
    input  lmbp_pkg::color_t      pal_upper,
    input  lmbp_pkg::color_t      pal_lower,
    output logic                  busy,
    output logic                  out_valid,
    input  logic                  out_stall,
    output lmbp_pkg::word_t       pixel_word,
    output lmbp_pkg::row_addr_t   row_address,
    output logic                  end_of_row
);

    localparam int CNT_W = $clog2(ROW_WIDTH);
    localparam int CMP_W = (CNT_W + 1 > lmbp_pkg::THR_W) ? CNT_W + 1 : lmbp_pkg::THR_W;

    function automatic logic [2:0] plane_bits(lmbp_pkg::color_t c, lmbp_pkg::bsel_t b);
        logic [7:0] lo_byte;
        logic [7:0] mid_byte;
        logic [7:0] hi_byte;
        lo_byte  = c[7:0];
        mid_byte = c[15:8];
        hi_byte  = c[23:16];
        return {lo_byte[b], mid_byte[b], hi_byte[b]};
    endfunction

    // stage 1 registers
    logic                s1_valid_reg;
    lmbp_pkg::color_t    s1_upper_reg;
    lmbp_pkg::color_t    s1_lower_reg;
    lmbp_pkg::pal_idx_t  s1_upper_ovl_reg;
    lmbp_pkg::pal_idx_t  s1_lower_ovl_reg;
    lmbp_pkg::bsel_t     s1_bsel_reg;
    lmbp_pkg::row_addr_t s1_row_reg;

    // row state
    logic [CNT_W-1:0]         count_reg;
    logic [CNT_W-1:0]         count_next;
    logic [lmbp_pkg::ACC_W-1:0] acc_reg;
    logic [lmbp_pkg::ACC_W-1:0] acc_next;

    // output register
    logic                out_valid_reg;
    lmbp_pkg::word_t     word_reg;
    lmbp_pkg::row_addr_t row_reg;
    logic                eor_reg;

    lmbp_pkg::color_t    upper_res;
    lmbp_pkg::color_t    lower_res;
    logic [CNT_W:0]      count_inc;
    logic                last;
    logic [1:0]          slot;
    logic                emits;
    logic                blank;
    logic [7:0]          pix_byte;
    lmbp_pkg::word_t     word_full;
    logic                out_free;
    logic                s1_done;

    always_comb
    begin
        upper_res = (s1_upper_ovl_reg != lmbp_pkg::PAL_NONE) ? pal_upper : s1_upper_reg;
        lower_res = (s1_lower_ovl_reg != lmbp_pkg::PAL_NONE) ? pal_lower : s1_lower_reg;
        count_inc = {1'b0, count_reg} + 1'b1;
        last      = count_inc >= (CNT_W + 1)'(ROW_WIDTH);
        slot      = count_reg[1:0];
        emits     = (slot == 2'd3) || last;
        blank     = CMP_W'(count_inc) > CMP_W'(threshold);
        pix_byte  = {blank, 1'b0, plane_bits(lower_res, s1_bsel_reg),
                     plane_bits(upper_res, s1_bsel_reg)};
        word_full = {8'h00, acc_reg} | (lmbp_pkg::WORD_W'(pix_byte) << {slot, 3'b000});
        out_free  = !out_valid_reg || !out_stall;
        s1_done   = s1_valid_reg && (!emits || out_free);
        busy      = s1_valid_reg && !s1_done;
        count_next = last ? '0 : count_inc[CNT_W-1:0];
        acc_next   = emits ? '0 : word_full[lmbp_pkg::ACC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            count_reg     <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.load)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_done)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_done)
            begin
                count_reg <= count_next;
                acc_reg   <= acc_next;
            end
            if (s1_done && emits)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_free)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.load)
        begin
            s1_upper_reg     <= req.upper_color;
            s1_lower_reg     <= req.lower_color;
            s1_upper_ovl_reg <= req.upper_overlay;
            s1_lower_ovl_reg <= req.lower_overlay;
            s1_bsel_reg      <= req.bit_select;
            s1_row_reg       <= req.row_index;
        end
        if (s1_done && emits)
        begin
            word_reg <= word_full;
            row_reg  <= s1_row_reg;
            eor_reg  <= last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_word  = word_reg;
    assign row_address = row_reg;
    assign end_of_row  = eor_reg;

    assert property (@(posedge clk) disable iff (!rst_n) (s1_done && emits) |=> out_valid_reg)
        else $error("emitted word lost");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_done && last) |=> (count_reg == '0) && (acc_reg == '0))
        else $error("row state not restarted after last pixel");

    assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (s1_valid_reg && out_valid_reg && out_stall))
        else $error("pixel stage held without output backpressure");

    assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, count_reg} < (CNT_W + 1)'(ROW_WIDTH))
        else $error("column count beyond row width");

endmodule

// ===== rtl/led_matrix_bit_plane_packer.sv =====
`timescale 1ns / 1ps
// An accepted pixel is captured in the pixel stage while the palette RAMs read;
// the word it completes is registered in the output register once that is free.
// Throughput: one request per cycle, except while in_stall is high.
// Palette writes produce no output.
// Reset: palette valid bits, column count, accumulator, threshold and valids clear
// at once (asynchronous, active low); no clearing pass is needed.
// ----------------------------------------------------------------------------
// led_matrix_bit_plane_packer
// Packs one color bit plane of a two-half LED panel into 32-bit words.
// ----------------------------------------------------------------------------
module led_matrix_bit_plane_packer #(
    parameter int ROW_WIDTH = lmbp_pkg::ROW_WIDTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    // configuration
    input  logic                cfg_wr_en,
    input  lmbp_pkg::thr_t      cfg_wr_data,
    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                opcode,
    input  lmbp_pkg::color_t    upper_color,
    input  lmbp_pkg::color_t    lower_color,
    input  lmbp_pkg::pal_idx_t  upper_overlay,
    input  lmbp_pkg::pal_idx_t  lower_overlay,
    input  lmbp_pkg::bsel_t     bit_select,
    input  lmbp_pkg::row_addr_t row_index,
    input  lmbp_pkg::pal_idx_t  palette_index,
    input  lmbp_pkg::color_t    palette_color,
    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output lmbp_pkg::word_t     pixel_word,
    output lmbp_pkg::row_addr_t row_address,
    output logic                end_of_row
);

    lmbp_pkg::thr_t     threshold_reg;
    logic               accept;
    logic               busy;
    lmbp_pkg::pal_wr_t  pal_wr;
    lmbp_pkg::pix_req_t pix_req;
    lmbp_pkg::color_t   pal_upper;
    lmbp_pkg::color_t   pal_lower;

    // Brightness threshold; user writes it only while the block is idle, unchecked.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    // Stall only when the pixel stage holds a word the output register cannot take.
    assign in_stall = busy;
    assign accept   = in_valid && !busy;

    // Route palette writes straight to the RAMs at the accept edge.
    always_comb
    begin
        pal_wr.en    = accept && (opcode == lmbp_pkg::OP_PALETTE);
        pal_wr.idx   = palette_index;
        pal_wr.color = palette_color;
    end

    // Launch pixel requests: palette read and pixel stage load on the same edge.
    always_comb
    begin
        pix_req.load          = accept && (opcode == lmbp_pkg::OP_PIXEL);
        pix_req.upper_color   = upper_color;
        pix_req.lower_color   = lower_color;
        pix_req.upper_overlay = upper_overlay;
        pix_req.lower_overlay = lower_overlay;
        pix_req.bit_select    = bit_select;
        pix_req.row_index     = row_index;
    end

    lmbp_palette u_palette (
        .clk          (clk),
        .rst_n        (rst_n),
        .wr           (pal_wr),
        .rd_en        (pix_req.load),
        .rd_idx_upper (upper_overlay),
        .rd_idx_lower (lower_overlay),
        .pal_upper    (pal_upper),
        .pal_lower    (pal_lower)
    );

    lmbp_plane_pack #(
        .ROW_WIDTH (ROW_WIDTH)
    ) u_plane_pack (
        .clk         (clk),
        .rst_n       (rst_n),
        .threshold   (threshold_reg),
        .req         (pix_req),
        .pal_upper   (pal_upper),
        .pal_lower   (pal_lower),
        .busy        (busy),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .pixel_word  (pixel_word),
        .row_address (row_address),
        .end_of_row  (end_of_row)
    );

endmodule
